/* rtl/kre_pkg.sv */
// Shared types, constants and helpers of the keyframe ramp evaluator.
`timescale 1ns / 1ps
package kre_pkg;

    localparam int TRACKS = 8;
    localparam int KEYS   = 16;                       // power of two: key address is {track, key}
    localparam int TW     = $clog2(TRACKS);           // track index width
    localparam int KPW    = $clog2(KEYS);             // key position width
    localparam int AW     = TW + KPW;                 // key memory address width
    localparam int CW     = $clog2(TRACKS + 1);       // track count width

    localparam int S_DATA_W = 184;                    // 182 bits of fields, padded to bytes
    localparam int M_DATA_W = 48;                     // 44 bits of fields, padded to bytes

    localparam logic [2:0] A_LOAD_KEY   = 3'd0;
    localparam logic [2:0] A_LOAD_SETUP = 3'd1;
    localparam logic [2:0] A_RESET      = 3'd2;
    localparam logic [2:0] A_ADVANCE    = 3'd3;
    localparam logic [2:0] A_FORCE      = 3'd4;

    typedef enum logic [4:0] {
        K_KEY   = 5'b00001,
        K_SETUP = 5'b00010,
        K_RESET = 5'b00100,
        K_ADV   = 5'b01000,
        K_FORCE = 5'b10000
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [2:0]  track_sel;
        logic [3:0]  key_sel;
        logic [31:0] key_time;
        logic [31:0] key_value;
        logic [31:0] key_slope;
        logic        curve_kind;
        logic [4:0]  key_total;
        logic        finish_mode;
        logic [31:0] loop_point;
        logic [7:0]  target_index;
        logic [31:0] time_step;
    } t_cmd;

    // index of the last key, key count clamped to [2, KEYS]
    function automatic logic [KPW-1:0] end_key(input logic [4:0] total);
        logic [8:0] n;
        n = {4'd0, total};
        if (n < 9'd2) n = 9'd2;
        if (n > 9'(KEYS)) n = 9'(KEYS);
        return KPW'(n - 9'd1);
    endfunction

endpackage

/* rtl/keyframe_ramp_evaluator.sv */
// Top level of the multi-track keyframe ramp evaluator.
`timescale 1ns / 1ps
// Keyframe ramp evaluator. Load beats fill per-track key tables (time, value, slope,
// curve) and track setup; reset, advance and force-time beats produce one result beat
// per active track, in track order, with tlast on the final one. A front end decodes
// and queues commands (two deep) so the input keeps flowing while the back end works
// or the output stalls, until the queue is full. Loads are applied in the back end as
// they are popped. Reset, advance and force are walked one track at a time through the
// key memory's single read port: last key read, key by key walk, loop wraps in the
// remainder unit (one bit per cycle), value sum; the result beats follow all tracks.
// Values are Q16.16: key value plus slope times elapsed time, rounded half away from
// zero, wrapping on overflow. all_finished is set when every active track's clock has
// reached the start time of its last key.
module keyframe_ramp_evaluator import kre_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration: active_tracks
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [3:0]          i_cfg_data,
    // input beat
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    // track_sel, key_sel, key_time, key_value, key_slope, curve_kind, key_total,
    // finish_mode, loop_point, target_index, time_step, zero pad
    input  logic [S_DATA_W-1:0] i_s_tdata,
    // action
    input  logic [2:0]          i_s_tuser,
    // result beat
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    // out_track, out_target, out_value, all_finished, zero pad
    output logic [M_DATA_W-1:0] o_m_tdata,
    output logic                o_m_tlast
);

    logic [3:0] r_active;
    logic       w_cmd_valid, w_pop;
    t_cmd       w_cmd;

    assign o_cfg_ready = 1'b1;

    // writes above the track count are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 4'd0;
        end else if (i_cfg_valid && 32'(i_cfg_data) <= TRACKS) begin
            r_active <= i_cfg_data;
        end
    end

    kre_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_active    (CW'(r_active)),
        .i_pop       (w_pop),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd)
    );

    kre_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_pop       (w_pop),
        .i_active    (CW'(r_active)),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

endmodule

/* rtl/kre_front.sv */
// Front end: accepts input beats, classifies them and queues commands.
`timescale 1ns / 1ps
module kre_front import kre_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [S_DATA_W-1:0] i_s_tdata,
    input  logic [2:0]          i_s_tuser,
    input  logic [CW-1:0]       i_active,
    input  logic                i_pop,
    output logic                o_cmd_valid,
    output t_cmd                o_cmd
);

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       w_cmd;
    logic       w_keep, w_push;

    always_comb begin
        w_cmd.kind         = K_KEY;
        w_cmd.track_sel    = i_s_tdata[2:0];
        w_cmd.key_sel      = i_s_tdata[6:3];
        w_cmd.key_time     = i_s_tdata[38:7];
        w_cmd.key_value    = i_s_tdata[70:39];
        w_cmd.key_slope    = i_s_tdata[102:71];
        w_cmd.curve_kind   = i_s_tdata[103];
        w_cmd.key_total    = i_s_tdata[108:104];
        w_cmd.finish_mode  = i_s_tdata[109];
        w_cmd.loop_point   = i_s_tdata[141:110];
        w_cmd.target_index = i_s_tdata[149:142];
        w_cmd.time_step    = i_s_tdata[181:150];
        w_keep = 1'b0;
        unique case (i_s_tuser)
            A_LOAD_KEY: begin
                w_cmd.kind = K_KEY;
                w_keep = (32'(w_cmd.track_sel) < TRACKS) && (32'(w_cmd.key_sel) < KEYS);
            end
            A_LOAD_SETUP: begin
                w_cmd.kind = K_SETUP;
                w_keep = 32'(w_cmd.track_sel) < TRACKS;
            end
            A_RESET: begin
                w_cmd.kind = K_RESET;
                w_keep = i_active != '0;
            end
            A_ADVANCE: begin
                w_cmd.kind = K_ADV;
                w_keep = i_active != '0;
            end
            A_FORCE: begin
                w_cmd.kind = K_FORCE;
                w_keep = i_active != '0;
            end
            default: w_keep = 1'b0;
        endcase
    end

    assign o_s_tready  = r_cnt != 2'd2;
    assign w_push      = i_s_tvalid && o_s_tready && w_keep;
    assign o_cmd_valid = r_cnt != 2'd0;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_cmd;
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_pop};
        end
    end

endmodule

/* rtl/kre_mod.sv */
// Restoring remainder unit, one quotient bit per cycle.
`timescale 1ns / 1ps
module kre_mod (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [31:0] o_rem
);

    logic        r_busy, r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_num, r_den, r_rem;
    logic [32:0] w_trial;

    assign w_trial = {r_rem, r_num[31]};
    assign o_done  = r_done;
    assign o_rem   = r_rem;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= 32'd0;
        end else if (r_busy) begin
            r_num <= {r_num[30:0], 1'b0};
            if (w_trial >= {1'b0, r_den}) r_rem <= 32'(w_trial - {1'b0, r_den});
            else r_rem <= w_trial[31:0];
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_done <= r_busy && (r_cnt == 5'd31);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) r_busy <= 1'b0;
            end
        end
    end

endmodule

/* rtl/kre_back.sv */
// Back end: key memory, track walk sequencer, result buffer and output register.
`timescale 1ns / 1ps
module kre_back import kre_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  t_cmd                i_cmd,
    output logic                o_pop,
    input  logic [CW-1:0]       i_active,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [M_DATA_W-1:0] o_m_tdata,
    output logic                o_m_tlast
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_DUR   = 10'b0000000010,
        S_DURW  = 10'b0000000100,
        S_WALK  = 10'b0000001000,
        S_WALKW = 10'b0000010000,
        S_MOD   = 10'b0000100000,
        S_VAL   = 10'b0001000000,
        S_VALW  = 10'b0010000000,
        S_SUM   = 10'b0100000000,
        S_EMIT  = 10'b1000000000
    } t_state;

    t_state r_state;
    t_cmd   r_cmd;

    // key memory: curve, slope, value, time
    logic [96:0]    r_kmem [TRACKS*KEYS];
    logic [96:0]    r_rd;
    logic [AW-1:0]  w_raddr;

    // track setup, undefined until loaded
    logic [4:0]  r_total  [TRACKS];
    logic        r_finish [TRACKS];
    logic [31:0] r_loop   [TRACKS];
    logic [7:0]  r_target [TRACKS];

    // track state
    logic [31:0]    r_clk [TRACKS];
    logic [KPW-1:0] r_pos [TRACKS];

    logic [TW-1:0]  r_t, r_e;
    logic [31:0]    r_wclk, r_dur;
    logic [KPW-1:0] r_wpos, r_end;
    logic           r_live, r_fin;
    logic [63:0]    r_prod;
    logic           r_neg, r_use;
    logic [31:0]    r_val;

    logic [31:0] r_bval [TRACKS];
    logic [7:0]  r_btgt [TRACKS];

    logic                r_ovalid, r_olast;
    logic [M_DATA_W-1:0] r_odata;

    logic        w_last_t, w_last_e, w_free;
    logic [32:0] w_sum, w_d, w_dn;
    logic [31:0] w_base, w_ad, w_as, w_mag, w_inc;
    logic [63:0] w_rnd;
    logic [KPW-1:0] w_np;
    logic        w_reach, w_wrap;
    logic        w_mstart, w_mdone;
    logic [31:0] w_mrem;

    assign o_pop    = (r_state == S_IDLE) && i_cmd_valid;
    assign w_last_t = (CW'(r_t) + CW'(1)) == i_active;
    assign w_last_e = (CW'(r_e) + CW'(1)) == i_active;
    assign w_free   = !r_ovalid || i_m_tready;

    assign w_base = (r_cmd.kind == K_ADV) ? r_clk[r_t] : 32'd0;
    assign w_sum  = {1'b0, w_base} + {1'b0, r_cmd.time_step};
    assign w_np   = r_wpos + KPW'(1);
    assign w_reach = r_wclk >= r_rd[31:0];
    assign w_wrap  = r_finish[r_t] && (r_loop[r_t] < r_dur);
    assign w_mstart = (r_state == S_WALKW) && w_reach && !(w_np < r_end) && w_wrap;

    assign w_d   = {1'b0, r_wclk} - {1'b0, r_rd[31:0]};
    assign w_dn  = 33'd0 - w_d;
    assign w_ad  = w_d[32] ? w_dn[31:0] : w_d[31:0];
    assign w_as  = r_rd[95] ? (32'd0 - r_rd[95:64]) : r_rd[95:64];
    assign w_rnd = r_prod + 64'h8000;
    assign w_mag = w_rnd[47:16];
    assign w_inc = r_neg ? (32'd0 - w_mag) : w_mag;

    always_comb begin
        case (r_state)
            S_DUR:   w_raddr = {r_t, end_key(r_total[r_t])};
            S_WALK:  w_raddr = {r_t, w_np};
            default: w_raddr = {r_t, r_wpos};
        endcase
    end

    kre_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mstart),
        .i_num   (r_wclk - r_dur),
        .i_den   (r_dur - r_loop[r_t]),
        .o_done  (w_mdone),
        .o_rem   (w_mrem)
    );

    // memory and payload registers
    always_ff @(posedge i_clk) begin
        r_rd <= r_kmem[w_raddr];
        if (o_pop && i_cmd.kind == K_KEY) begin
            r_kmem[{i_cmd.track_sel[TW-1:0], i_cmd.key_sel[KPW-1:0]}] <=
                {i_cmd.curve_kind, i_cmd.key_slope, i_cmd.key_value, i_cmd.key_time};
        end
        if (o_pop && i_cmd.kind == K_SETUP) begin
            r_total[i_cmd.track_sel[TW-1:0]]  <= i_cmd.key_total;
            r_finish[i_cmd.track_sel[TW-1:0]] <= i_cmd.finish_mode;
            r_loop[i_cmd.track_sel[TW-1:0]]   <= i_cmd.loop_point;
            r_target[i_cmd.track_sel[TW-1:0]] <= i_cmd.target_index;
        end
        if (o_pop) r_cmd <= i_cmd;
        case (r_state)
            S_DUR: begin
                r_end  <= end_key(r_total[r_t]);
                r_wpos <= (r_cmd.kind == K_ADV) ? r_pos[r_t] : '0;
                r_wclk <= (r_cmd.kind == K_RESET) ? 32'd0
                        : (w_sum[32] ? 32'hFFFF_FFFF : w_sum[31:0]);
            end
            S_DURW: begin
                r_dur  <= r_rd[31:0];
                r_live <= 1'b1;
                if (r_cmd.kind == K_RESET) begin
                    r_live <= 1'b0;
                end else if (r_wpos >= r_end) begin
                    r_wpos <= r_end;
                    r_wclk <= r_rd[31:0];
                    r_live <= 1'b0;
                end
            end
            S_WALKW: begin
                if (w_reach) begin
                    if (w_np < r_end) begin
                        r_wpos <= w_np;
                    end else if (!w_wrap) begin
                        r_wpos <= r_end;
                        r_wclk <= r_dur;
                        r_live <= 1'b0;
                    end
                end
            end
            S_MOD: begin
                if (w_mdone) begin
                    r_wclk <= r_loop[r_t] + w_mrem;
                    r_wpos <= '0;
                end
            end
            S_VALW: begin
                r_prod <= 64'(w_ad) * 64'(w_as);
                r_neg  <= w_d[32] != r_rd[95];
                r_use  <= r_live && r_rd[96];
                r_val  <= r_rd[63:32];
            end
            S_SUM: begin
                r_bval[r_t] <= r_use ? (r_val + w_inc) : r_val;
                r_btgt[r_t] <= r_target[r_t];
            end
            default: ;
        endcase
        if (r_state == S_EMIT && w_free) begin
            r_odata <= {4'd0, r_fin, r_bval[r_e], r_btgt[r_e], 3'(r_e)};
            r_olast <= w_last_e;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_t      <= '0;
            r_e      <= '0;
            r_fin    <= 1'b1;
            r_ovalid <= 1'b0;
            for (int i = 0; i < TRACKS; i++) begin
                r_clk[i] <= 32'd0;
                r_pos[i] <= '0;
            end
        end else begin
            if (r_state == S_EMIT && w_free) r_ovalid <= 1'b1;
            else if (i_m_tready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop && (i_cmd.kind == K_RESET || i_cmd.kind == K_ADV
                                  || i_cmd.kind == K_FORCE)) begin
                        r_t     <= '0;
                        r_fin   <= 1'b1;
                        r_state <= S_DUR;
                    end
                end
                S_DUR:  r_state <= S_DURW;
                S_DURW: begin
                    if (r_cmd.kind == K_RESET || r_wpos >= r_end) r_state <= S_VAL;
                    else r_state <= S_WALK;
                end
                S_WALK:  r_state <= S_WALKW;
                S_WALKW: begin
                    if (w_reach && w_np < r_end) r_state <= S_WALK;
                    else if (w_mstart) r_state <= S_MOD;
                    else r_state <= S_VAL;
                end
                S_MOD: begin
                    if (w_mdone) r_state <= S_WALK;
                end
                S_VAL: begin
                    r_clk[r_t] <= r_wclk;
                    r_pos[r_t] <= r_wpos;
                    if (r_wclk < r_dur) r_fin <= 1'b0;
                    r_state <= S_VALW;
                end
                S_VALW: r_state <= S_SUM;
                S_SUM: begin
                    if (w_last_t) begin
                        r_e     <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        r_t     <= r_t + TW'(1);
                        r_state <= S_DUR;
                    end
                end
                S_EMIT: begin
                    if (w_free) begin
                        r_e      <= r_e + TW'(1);
                        if (w_last_e) r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tlast  = r_olast;

endmodule

/* tb/keyframe_ramp_evaluator_tb.sv */
// Self-checking testbench for the keyframe ramp evaluator.
`timescale 1ns / 1ps
module keyframe_ramp_evaluator_tb;
    import kre_pkg::*;

    // spare action codes, decoded as no-ops by the block
    localparam logic [2:0] A_SPARE5 = 3'd5;
    localparam logic [2:0] A_SPARE6 = 3'd6;
    localparam logic [2:0] A_SPARE7 = 3'd7;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE = 1500;  // back-end settle time after a drain, with margin

    typedef struct {
        logic [2:0]  action;
        logic [2:0]  track_sel;
        logic [3:0]  key_sel;
        logic [31:0] key_time;
        logic [31:0] key_value;
        logic [31:0] key_slope;
        logic        curve_kind;
        logic [4:0]  key_total;
        logic        finish_mode;
        logic [31:0] loop_point;
        logic [7:0]  target_index;
        logic [31:0] time_step;
    } t_ramp_cmd;

    typedef struct {
        logic [2:0]  track;
        logic [7:0]  target;
        logic [31:0] value;
        logic        all_done;
        logic        last;
    } t_ramp_out;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [3:0]          i_cfg_data = '0;
    logic                i_s_tvalid = 1'b0;
    logic                o_s_tready;
    logic [S_DATA_W-1:0] i_s_tdata = '0;
    logic [2:0]          i_s_tuser = '0;
    logic                o_m_tvalid;
    logic                i_m_tready = 1'b0;
    logic [M_DATA_W-1:0] o_m_tdata;
    logic                o_m_tlast;

    keyframe_ramp_evaluator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Shadow copy of the ramp state
    // ---------------------------------------------------------------
    logic [31:0] kt_mem [TRACKS][KEYS];
    logic [31:0] kv_mem [TRACKS][KEYS];
    logic [31:0] ks_mem [TRACKS][KEYS];
    logic        kc_mem [TRACKS][KEYS];
    logic [4:0]  trk_total  [TRACKS];
    logic        trk_loops  [TRACKS];
    logic [31:0] trk_loopat [TRACKS];
    logic [7:0]  trk_target [TRACKS];
    logic [31:0] trk_clock  [TRACKS];
    logic [3:0]  trk_pos    [TRACKS];
    int          live_tracks = 0;

    t_ramp_out   expected_beats[$];
    t_ramp_cmd   pending_cmds[$];
    int          errors = 0;
    bit          rst_done = 1'b0;
    bit          quiet = 1'b0;      // no idling on either side
    int          hold_request = 0;  // long receiver hold-off, picked up by the receiver

    function automatic logic [3:0] last_key(input int t);
        int n;
        n = trk_total[t];
        if (n < 2) n = 2;
        if (n > KEYS) n = KEYS;
        return 4'(n - 1);
    endfunction

    // Step one track by dt, return its new value
    function automatic logic [31:0] step_track(input int t, input logic [31:0] dt);
        logic [3:0]  e;
        logic [31:0] dur, clk, v, inc;
        logic [32:0] sum;
        int          pos;
        bit          live;
        longint      d, s;
        logic [63:0] ad, as_, r;
        e = last_key(t);
        dur = kt_mem[t][e];
        sum = {1'b0, trk_clock[t]} + {1'b0, dt};
        clk = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        pos = trk_pos[t];
        live = 1'b1;
        if (pos >= e) begin  // stale or held position
            pos = e;
            clk = dur;
            live = 1'b0;
        end
        while (live && clk >= kt_mem[t][pos + 1]) begin
            pos++;
            if (pos < e) continue;
            if (trk_loops[t] && trk_loopat[t] < dur) begin
                clk = trk_loopat[t] + (clk - dur) % (dur - trk_loopat[t]);
                pos = 0;
            end else begin
                pos = e;
                clk = dur;
                live = 1'b0;
            end
        end
        trk_clock[t] = clk;
        trk_pos[t] = 4'(pos);
        v = kv_mem[t][pos];
        if (live && kc_mem[t][pos]) begin
            d = longint'({32'd0, clk}) - longint'({32'd0, kt_mem[t][pos]});
            s = longint'($signed(ks_mem[t][pos]));
            ad = d < 0 ? 64'(-d) : 64'(d);
            as_ = s < 0 ? 64'(-s) : 64'(s);
            r = (ad * as_ + 64'h8000) >> 16;
            inc = ((d < 0) != (s < 0)) ? -r[31:0] : r[31:0];
            v = v + inc;
        end
        return v;
    endfunction

    // Apply one accepted beat to the shadow state, queue the beats it causes
    function automatic void predict_ramp(input t_ramp_cmd c);
        logic [31:0] vals [TRACKS];
        bit          done;
        t_ramp_out   o;
        case (c.action)
            A_LOAD_KEY: begin
                kt_mem[c.track_sel][c.key_sel] = c.key_time;
                kv_mem[c.track_sel][c.key_sel] = c.key_value;
                ks_mem[c.track_sel][c.key_sel] = c.key_slope;
                kc_mem[c.track_sel][c.key_sel] = c.curve_kind;
            end
            A_LOAD_SETUP: begin
                trk_total[c.track_sel] = c.key_total;
                trk_loops[c.track_sel] = c.finish_mode;
                trk_loopat[c.track_sel] = c.loop_point;
                trk_target[c.track_sel] = c.target_index;
            end
            A_RESET, A_ADVANCE, A_FORCE: begin
                if (live_tracks == 0) return;
                if (c.action != A_ADVANCE)
                    for (int t = 0; t < live_tracks; t++) begin
                        trk_clock[t] = '0;
                        trk_pos[t] = '0;
                    end
                for (int t = 0; t < live_tracks; t++)
                    vals[t] = (c.action == A_RESET) ? kv_mem[t][0] : step_track(t, c.time_step);
                done = 1'b1;
                for (int t = 0; t < live_tracks; t++)
                    if (trk_clock[t] < kt_mem[t][last_key(t)]) done = 1'b0;
                for (int t = 0; t < live_tracks; t++) begin
                    o.track = 3'(t);
                    o.target = trk_target[t];
                    o.value = vals[t];
                    o.all_done = done;
                    o.last = (t + 1 == live_tracks);
                    expected_beats.push_back(o);
                end
            end
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Input driver: beats change on the falling edge
    // ---------------------------------------------------------------
    t_ramp_cmd cur_cmd;
    bit        s_busy = 1'b0;
    bit        s_took = 1'b0;
    bit        s_on = 1'b0;
    int        s_gap = 0;

    always @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            predict_ramp(cur_cmd);
            s_took = 1'b1;
        end
    end

    always @(negedge i_clk) begin
        if (rst_done) begin
            if (s_took) begin
                s_on = 1'b0;
                s_busy = 1'b0;
                s_took = 1'b0;
            end
            if (!s_busy && pending_cmds.size() > 0) begin
                cur_cmd = pending_cmds.pop_front();
                s_gap = quiet ? 0 : $urandom_range(0, 19);
                s_busy = 1'b1;
            end
            if (s_busy && !s_on) begin
                if (s_gap == 0) begin
                    s_on = 1'b1;
                    i_s_tuser <= cur_cmd.action;
                    i_s_tdata <= {2'b00, cur_cmd.time_step, cur_cmd.target_index,
                                  cur_cmd.loop_point, cur_cmd.finish_mode,
                                  cur_cmd.key_total, cur_cmd.curve_kind, cur_cmd.key_slope,
                                  cur_cmd.key_value, cur_cmd.key_time, cur_cmd.key_sel,
                                  cur_cmd.track_sel};
                end else begin
                    s_gap--;
                end
            end
            i_s_tvalid <= s_on;
        end
    end

    // ---------------------------------------------------------------
    // Result monitor and receiver stalls
    // ---------------------------------------------------------------
    int r_wait = 0;
    int r_hold = 0;

    always @(posedge i_clk) begin
        t_ramp_out e;
        if (o_m_tvalid && i_m_tready) begin
            r_wait = quiet ? 0 : $urandom_range(0, 19);
            if (expected_beats.size() == 0) begin
                $error("result beat with nothing expected: data %h", o_m_tdata);
                errors++;
            end else begin
                e = expected_beats.pop_front();
                if (o_m_tdata[2:0] !== e.track) begin
                    $error("out_track: expected %0d, got %0d", e.track, o_m_tdata[2:0]);
                    errors++;
                end
                if (o_m_tdata[10:3] !== e.target) begin
                    $error("out_target: expected %0d, got %0d", e.target, o_m_tdata[10:3]);
                    errors++;
                end
                if (o_m_tdata[42:11] !== e.value) begin
                    $error("out_value: expected %h, got %h", e.value, o_m_tdata[42:11]);
                    errors++;
                end
                if (o_m_tdata[43] !== e.all_done) begin
                    $error("all_finished: expected %b, got %b", e.all_done, o_m_tdata[43]);
                    errors++;
                end
                if (o_m_tlast !== e.last) begin
                    $error("last: expected %b, got %b", e.last, o_m_tlast);
                    errors++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (rst_done) begin
            if (hold_request > 0) begin
                r_hold = hold_request;
                hold_request = 0;
            end
            if (r_hold > 0) begin
                r_hold--;
                i_m_tready <= 1'b0;
            end else if (r_wait > 0) begin
                r_wait--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // watchdog
    int cycles = 0;
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    function automatic t_ramp_cmd blank_cmd(input logic [2:0] act);
        t_ramp_cmd c;
        c.action = act;
        c.track_sel = 3'($urandom);
        c.key_sel = 4'($urandom);
        c.key_time = $urandom;
        c.key_value = $urandom;
        c.key_slope = $urandom;
        c.curve_kind = 1'($urandom);
        c.key_total = 5'($urandom);
        c.finish_mode = 1'($urandom);
        c.loop_point = $urandom;
        c.target_index = 8'($urandom);
        c.time_step = $urandom;
        return c;
    endfunction

    // Key with a start time that mostly rises with its slot
    function automatic t_ramp_cmd key_cmd(input int t, input int k);
        t_ramp_cmd c;
        c = blank_cmd(A_LOAD_KEY);
        c.track_sel = 3'(t);
        c.key_sel = 4'(k);
        if ($urandom_range(0, 9) != 0)
            c.key_time = 32'(k) * 32'h2_0000 + $urandom_range(0, 32'h1_FFFF);
        if ($urandom_range(0, 3) != 0)
            c.key_slope = 32'($signed($urandom_range(0, 32'h40_0000)) - 32'sh20_0000);
        return c;
    endfunction

    function automatic t_ramp_cmd setup_cmd(input int t);
        t_ramp_cmd c;
        c = blank_cmd(A_LOAD_SETUP);
        c.track_sel = 3'(t);
        if ($urandom_range(0, 4) != 0) c.key_total = 5'($urandom_range(2, 16));
        if ($urandom_range(0, 4) != 0) c.loop_point = $urandom_range(0, 32'h6_0000);
        return c;
    endfunction

    function automatic t_ramp_cmd random_cmd();
        t_ramp_cmd c;
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)       c = key_cmd($urandom_range(0, 7), $urandom_range(0, 15));
        else if (r < 12) c = setup_cmd($urandom_range(0, 7));
        else if (r < 20) c = blank_cmd(A_RESET);
        else if (r < 92) begin
            c = blank_cmd(r < 76 ? A_ADVANCE : A_FORCE);
            if ($urandom_range(0, 9) != 0) c.time_step = $urandom_range(0, 32'h3_0000);
        end else begin
            c = blank_cmd(3'($urandom_range(A_SPARE5, A_SPARE7)));
        end
        return c;
    endfunction

    task automatic push_cmd(input logic [2:0] act, input logic [31:0] dt);
        t_ramp_cmd c;
        c = blank_cmd(act);
        c.time_step = dt;
        pending_cmds.push_back(c);
    endtask

    // Wait until every beat is sent and every result is in, then let the back end settle
    task automatic drain();
        while (pending_cmds.size() > 0 || s_busy || expected_beats.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_track_count(input logic [3:0] n);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= n;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (n <= TRACKS) live_tracks = n;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        t_ramp_cmd c;
        int counts [7] = '{8, 3, 1, 8, 0, 5, 8};
        for (int t = 0; t < TRACKS; t++) begin
            trk_clock[t] = '0;
            trk_pos[t] = '0;
        end
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        rst_done = 1'b1;

        // nothing is active yet: these must stay silent
        push_cmd(A_RESET, 0);
        push_cmd(A_ADVANCE, 32'h1_0000);
        // fill every key and every track setup so nothing unwritten is read
        for (int t = 0; t < TRACKS; t++) begin
            for (int k = 0; k < KEYS; k++) pending_cmds.push_back(key_cmd(t, k));
            pending_cmds.push_back(setup_cmd(t));
        end
        drain();
        write_track_count(4'd8);

        // directed: start, zero and small steps, clock saturation
        push_cmd(A_RESET, 0);
        push_cmd(A_ADVANCE, 0);
        push_cmd(A_ADVANCE, 32'h0_8000);
        push_cmd(A_ADVANCE, 32'hFFFF_FFFF);
        push_cmd(A_FORCE, 32'h0_C000);
        push_cmd(A_FORCE, 32'hFFFF_FFFF);
        push_cmd(A_SPARE5, 0);
        push_cmd(A_SPARE6, 0);
        push_cmd(A_SPARE7, 0);
        // extreme value and slope on the first key of tracks 0 and 1
        c = key_cmd(0, 0);
        c.key_time = 32'h0;
        c.key_value = 32'h7FFF_FFFF;
        c.key_slope = 32'h8000_0000;
        c.curve_kind = 1'b1;
        pending_cmds.push_back(c);
        c = key_cmd(1, 0);
        c.key_time = 32'h0;
        c.key_value = 32'h8000_0000;
        c.key_slope = 32'h7FFF_FFFF;
        c.curve_kind = 1'b1;
        pending_cmds.push_back(c);
        // key count clamps, a degenerate loop point, a stale position
        c = setup_cmd(2); c.key_total = 5'd0;  pending_cmds.push_back(c);
        c = setup_cmd(3); c.key_total = 5'd31; pending_cmds.push_back(c);
        c = setup_cmd(4); c.finish_mode = 1'b1; c.loop_point = 32'hFFFF_FFFF;
        pending_cmds.push_back(c);
        push_cmd(A_RESET, 0);
        push_cmd(A_ADVANCE, 32'h1_8000);
        push_cmd(A_ADVANCE, 32'h7_0000);
        c = setup_cmd(5); c.key_total = 5'd2; pending_cmds.push_back(c);
        push_cmd(A_ADVANCE, 32'h0_4000);
        push_cmd(A_ADVANCE, 32'h40_0000);
        drain();

        // oversized count is ignored, zero tracks stay silent
        write_track_count(4'd15);
        push_cmd(A_ADVANCE, 32'h1_0000);
        drain();
        write_track_count(4'd0);
        push_cmd(A_FORCE, 32'h1_0000);
        push_cmd(A_RESET, 0);
        drain();

        // random phases over several track counts
        for (int p = 0; p < 7; p++) begin
            write_track_count(4'(counts[p]));
            quiet = (p == 2);
            if (p == 3) hold_request = 600;  // back the block up
            pending_cmds.push_back(blank_cmd(A_RESET));
            for (int i = 0; i < 16; i++) pending_cmds.push_back(random_cmd());
            drain();
        end
        quiet = 1'b0;

        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
